// File: rtl/cbf_pkg.sv
`default_nettype none

package cbf_pkg;

  localparam int BUFFER_BYTES = 64;

  // Nine buffer bytes cover any field of up to 64 bits at any bit offset
  localparam int ACC_W = 72;

  localparam logic [63:0] FULL_MASK = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [8:0]  SEQ_XOR   = 9'h007;

  localparam logic [2:0] MODE_GET_MOT   = 3'd0;
  localparam logic [2:0] MODE_SET_MOT   = 3'd1;
  localparam logic [2:0] MODE_GET_INTEL = 3'd2;
  localparam logic [2:0] MODE_SET_INTEL = 3'd3;
  localparam logic [2:0] MODE_BYTE_RD   = 3'd4;
  localparam logic [2:0] MODE_BYTE_WR   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MERGE,
    ST_WRITE
  } cbf_state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [8:0]  bit_pos;
    logic [6:0]  bit_size;
    logic [5:0]  byte_index;
    logic [63:0] write_value;
  } cbf_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        error;
  } cbf_rsp_t;

  // Placement of a field inside the gathered bytes
  typedef struct packed {
    logic [2:0] sh;
    logic [6:0] size;
  } cbf_fld_t;

  // Low size bits set, size in 1..64
  function automatic logic [63:0] field_mask(input logic [6:0] size);
    logic [6:0] amt;
    amt = 7'd64 - size;
    return FULL_MASK >> amt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cbf_ram.sv
`default_nettype none

module cbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/cbf_merge.sv
`default_nettype none

module cbf_merge (
  input  wire logic [cbf_pkg::ACC_W-1:0] acc_i,
  input  wire cbf_pkg::cbf_fld_t         fld_i,
  input  wire logic [63:0]               wval_i,
  output logic      [63:0]               field_o,
  output logic      [cbf_pkg::ACC_W-1:0] merged_o
);

  import cbf_pkg::*;

  logic [63:0]      mask;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W-1:0] mask_wide;
  logic [ACC_W-1:0] data_wide;

  always_comb begin
    mask      = field_mask(fld_i.size);
    shifted   = acc_i >> fld_i.sh;
    field_o   = shifted[63:0] & mask;
    mask_wide = {8'h00, mask} << fld_i.sh;
    data_wide = {8'h00, wval_i & mask} << fld_i.sh;
    // keep bits outside the field, replace the field
    merged_o  = (acc_i & ~mask_wide) | data_wide;
  end

endmodule

`default_nettype wire

// File: rtl/can_signal_bitfield_access.sv
// Bit field access to a byte-addressed CAN frame buffer.
//
// Command channel: a word on req_i is taken at a clock edge where start is
// high and busy is low. Each command returns exactly one word on rsp_o,
// marked by done_o for one cycle; the receiver cannot stall it, and a new
// command may be issued in that same cycle.
//
// A field or byte access touches n buffer bytes, n = 1..9. The buffer sits
// in a single-port RAM, one byte per cycle, so the sequencer reads the n
// bytes, drains the last read, merges and, for a write, stores the n bytes
// back; done_o follows the merge for a read and the last byte stored for a
// write. A no-op or a field out of buffer answers in the cycle after the
// accepting edge. busy stays high until the result is issued.
//
// Reset clears the per-byte valid flags, so the whole buffer reads as zero
// at once; there is no clearing pass.
`default_nettype none

module can_signal_bitfield_access #(
  parameter int BufferBytes = cbf_pkg::BUFFER_BYTES
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cbf_pkg::cbf_req_t req_i,
  output logic                   done_o,
  output cbf_pkg::cbf_rsp_t      rsp_o
);

  import cbf_pkg::*;

  localparam int AddrW = $clog2(BufferBytes);

  cbf_state_e state_q, state_d;

  logic             accept;
  logic             is_field, is_byte;
  logic             dec_mot, dec_wr, dec_noop, dec_err, dec_skip;
  logic [8:0]       dec_start;
  logic [6:0]       dec_size, size_sat;
  logic [8:0]       seq_first;
  logic [9:0]       seq_last;
  logic [5:0]       byte_first;
  logic [6:0]       byte_last;
  logic [6:0]       byte_span;
  logic [3:0]       dec_n;
  logic [2:0]       dec_sh;
  logic [AddrW-1:0] dec_addr;

  logic             mot_q, is_wr_q;
  cbf_fld_t         fld_q;
  logic [63:0]      wval_q;
  logic [3:0]       n_q, cnt_q;
  logic [AddrW-1:0] addr_q;
  logic [ACC_W-1:0] acc_q, wbuf_q;
  logic             rd_pend_q, vld_rd_q;
  logic [BufferBytes-1:0] vld_q;
  logic             done_q;
  cbf_rsp_t         rsp_q;

  logic             load_cmd, step_addr, load_wbuf;
  logic             emit, emit_rd, emit_err;
  logic             ram_re, ram_we;
  logic [7:0]       ram_rdata, rd_byte;
  logic [63:0]      field_val;
  logic [ACC_W-1:0] merged;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Command decode: byte modes run as 8-bit Intel fields
  always_comb begin
    is_field   = (req_i.mode == MODE_GET_MOT) || (req_i.mode == MODE_SET_MOT) ||
                 (req_i.mode == MODE_GET_INTEL) || (req_i.mode == MODE_SET_INTEL);
    is_byte    = (req_i.mode == MODE_BYTE_RD) || (req_i.mode == MODE_BYTE_WR);
    dec_mot    = (req_i.mode == MODE_GET_MOT) || (req_i.mode == MODE_SET_MOT);
    dec_wr     = (req_i.mode == MODE_SET_MOT) || (req_i.mode == MODE_SET_INTEL) ||
                 (req_i.mode == MODE_BYTE_WR);
    size_sat   = (req_i.bit_size > 7'd64) ? 7'd64 : req_i.bit_size;
    dec_start  = is_byte ? {req_i.byte_index, 3'b000} : req_i.bit_pos;
    dec_size   = is_byte ? 7'd8 : size_sat;
    dec_noop   = !(is_field || is_byte) || (is_field && (req_i.bit_size == 7'd0));
    seq_first  = dec_mot ? (dec_start ^ SEQ_XOR) : dec_start;
    seq_last   = 10'(seq_first) + 10'(dec_size) - 10'd1;
    byte_first = dec_start[8:3];
    byte_last  = seq_last[9:3];
    dec_err    = !dec_noop && ({3'b000, byte_last} >= 10'(BufferBytes));
    dec_skip   = dec_noop || dec_err;
    // Motorola LSB sits at 7 - (last & 7) in the big-endian gather
    dec_sh     = dec_mot ? ~seq_last[2:0] : dec_start[2:0];
    byte_span  = byte_last - {1'b0, byte_first};
    dec_n      = byte_span[3:0];
    // Motorola gathers ascending, Intel descending; write back runs the other way
    dec_addr   = dec_mot ? AddrW'(byte_first) : AddrW'(byte_last);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !dec_skip) state_d = ST_READ;
      end
      ST_READ: begin
        if (cnt_q == 4'd0) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_MERGE;
      ST_MERGE: state_d = is_wr_q ? ST_WRITE : ST_IDLE;
      ST_WRITE: begin
        if (cnt_q == 4'd0) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load_cmd  = 1'b0;
    step_addr = 1'b0;
    load_wbuf = 1'b0;
    emit      = 1'b0;
    emit_rd   = 1'b0;
    emit_err  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (dec_skip) begin
            emit     = 1'b1;
            emit_err = dec_err;
          end else begin
            load_cmd = 1'b1;
          end
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        step_addr = (cnt_q != 4'd0);
      end
      ST_DRAIN: ;
      ST_MERGE: begin
        load_wbuf = 1'b1;
        emit      = !is_wr_q;
        emit_rd   = !is_wr_q;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        step_addr = (cnt_q != 4'd0);
        emit      = (cnt_q == 4'd0);
      end
      default: ;
    endcase
  end

  assign rd_byte = vld_rd_q ? ram_rdata : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 4'd0;
      addr_q    <= '0;
      rd_pend_q <= 1'b0;
      vld_rd_q  <= 1'b0;
      vld_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= ram_re;
      done_q    <= emit;
      if (ram_re) begin
        vld_rd_q <= vld_q[addr_q];
      end
      if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (load_cmd) begin
        cnt_q  <= dec_n;
        addr_q <= dec_addr;
      end else if (load_wbuf) begin
        cnt_q <= n_q;
      end else if (step_addr) begin
        cnt_q <= cnt_q - 4'd1;
        // advance along the gather order while reading, back along it while writing
        if ((state_q == ST_READ) == mot_q) begin
          addr_q <= addr_q + AddrW'(1);
        end else begin
          addr_q <= addr_q - AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      mot_q      <= dec_mot;
      is_wr_q    <= dec_wr;
      fld_q.sh   <= dec_sh;
      fld_q.size <= dec_size;
      wval_q     <= req_i.write_value;
      n_q        <= dec_n;
    end
    if (rd_pend_q) begin
      acc_q <= {acc_q[ACC_W-9:0], rd_byte};
    end
    if (load_wbuf) begin
      wbuf_q <= merged;
    end else if (ram_we) begin
      wbuf_q <= wbuf_q >> 8;
    end
    if (emit) begin
      rsp_q.read_value <= emit_rd ? field_val : 64'd0;
      rsp_q.error      <= emit_err;
    end
  end

  cbf_merge u_merge (
    .acc_i   (acc_q),
    .fld_i   (fld_q),
    .wval_i  (wval_q),
    .field_o (field_val),
    .merged_o(merged)
  );

  cbf_ram #(
    .Width(8),
    .Depth(BufferBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (addr_q),
    .wdata_i(wbuf_q[7:0]),
    .rdata_o(ram_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result issued while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.error) |-> (rsp_o.read_value == 64'd0))
    else $error("error result carries data");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted command neither started nor answered");

  a_write_only_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> is_wr_q)
    else $error("buffer written by a read command");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("byte count beyond nine bytes");

endmodule

`default_nettype wire

// File: dv/tb_can_signal_bitfield_access.sv
module tb_can_signal_bitfield_access;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  localparam logic [2:0] MODE_NOP_A = 3'd6;
  localparam logic [2:0] MODE_NOP_B = 3'd7;

  localparam int RANDOM_WORDS = 1530;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 30;

  typedef struct {
    cbf_req_t req;
    bit       typed;
    cbf_rsp_t rsp;
  } word_row_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  cbf_req_t req_i  = '0;
  logic     done_o;
  cbf_rsp_t rsp_o;

  logic [7:0]  frame_mirror [BUFFER_BYTES];
  word_row_t   word_q [$];
  cbf_rsp_t    due_rsp_q [$];
  int unsigned sent_cnt     = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;

  can_signal_bitfield_access uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #10ns clk_i = ~clk_i;
  end

  // Apply one access to the mirror and return what the block should answer
  function automatic cbf_rsp_t access_frame(input cbf_req_t r);
    cbf_rsp_t    rsp;
    logic        motorola;
    int unsigned size;
    int unsigned sp;
    int unsigned last;
    int unsigned p;
    rsp = '0;
    sp = r.bit_pos;
    if (r.mode == MODE_GET_MOT || r.mode == MODE_SET_MOT ||
        r.mode == MODE_GET_INTEL || r.mode == MODE_SET_INTEL) begin
      motorola = (r.mode == MODE_GET_MOT) || (r.mode == MODE_SET_MOT);
      size = (r.bit_size > 7'd64) ? 64 : r.bit_size;
      if (size != 0) begin
        last = motorola ? (sp ^ 32'd7) + size - 1 : sp + size - 1;
        if ((last >> 3) >= BUFFER_BYTES) begin
          rsp.error = 1'b1;
        end else begin
          for (int i = 0; i < size; i++) begin
            p = motorola ? (((sp ^ 32'd7) + size - 1 - i) ^ 32'd7) : sp + i;
            if (r.mode == MODE_SET_MOT || r.mode == MODE_SET_INTEL) begin
              frame_mirror[p >> 3][p % 8] = r.write_value[i];
            end else begin
              rsp.read_value[i] = frame_mirror[p >> 3][p % 8];
            end
          end
        end
      end
    end else if (r.mode == MODE_BYTE_RD || r.mode == MODE_BYTE_WR) begin
      if (r.byte_index >= BUFFER_BYTES) begin
        rsp.error = 1'b1;
      end else if (r.mode == MODE_BYTE_RD) begin
        rsp.read_value = {56'd0, frame_mirror[r.byte_index]};
      end else begin
        frame_mirror[r.byte_index] = r.write_value[7:0];
      end
    end
    return rsp;
  endfunction

  task automatic add_word(input logic [2:0] mode, input logic [8:0] pos,
                          input logic [6:0] size, input logic [5:0] idx,
                          input logic [63:0] val, input bit typed = 1'b0,
                          input logic [63:0] rv = '0, input logic er = 1'b0);
    word_row_t row;
    row.req.mode        = mode;
    row.req.bit_pos     = pos;
    row.req.bit_size    = size;
    row.req.byte_index  = idx;
    row.req.write_value = val;
    row.typed           = typed;
    row.rsp.read_value  = rv;
    row.rsp.error       = er;
    word_q.push_back(row);
  endtask

  task automatic build_directed();
    // fresh buffer reads as zero
    add_word(MODE_GET_INTEL, 9'd0, 7'd64, 6'd0, FULL_MASK, 1'b1, '0, 1'b0);
    add_word(MODE_GET_MOT, 9'd7, 7'd64, 6'd0, '0, 1'b1, '0, 1'b0);
    add_word(MODE_BYTE_RD, 9'd0, 7'd1, 6'd63, '0, 1'b1, '0, 1'b0);
    add_word(MODE_SET_INTEL, 9'd0, 7'd64, 6'd0, FULL_MASK, 1'b1, '0, 1'b0);
    add_word(MODE_GET_INTEL, 9'd0, 7'd64, 6'd0, '0, 1'b1, FULL_MASK, 1'b0);
    add_word(MODE_BYTE_WR, 9'd0, 7'd1, 6'd63, 64'h5A5A_5A5A_5A5A_5AA5, 1'b1, '0, 1'b0);
    add_word(MODE_BYTE_RD, 9'd0, 7'd1, 6'd63, '0, 1'b1, 64'hA5, 1'b0);
    add_word(MODE_SET_MOT, 9'd7, 7'd64, 6'd0, 64'h0123_4567_89AB_CDEF);
    add_word(MODE_GET_MOT, 9'd7, 7'd64, 6'd0, '0);
    add_word(MODE_GET_INTEL, 9'd0, 7'd64, 6'd0, '0);
    add_word(MODE_GET_INTEL, 9'd511, 7'd1, 6'd0, '0);
    // fields running past the last byte, then one that ends on it
    add_word(MODE_GET_INTEL, 9'd511, 7'd2, 6'd0, '0, 1'b1, '0, 1'b1);
    add_word(MODE_SET_INTEL, 9'd449, 7'd64, 6'd0, FULL_MASK, 1'b1, '0, 1'b1);
    add_word(MODE_GET_MOT, 9'd504, 7'd8, 6'd0, '0, 1'b1, '0, 1'b1);
    add_word(MODE_SET_MOT, 9'd511, 7'd8, 6'd0, 64'h3C);
    add_word(MODE_GET_MOT, 9'd511, 7'd8, 6'd0, '0);
    // zero width does nothing
    add_word(MODE_GET_INTEL, 9'd0, 7'd0, 6'd0, '0, 1'b1, '0, 1'b0);
    add_word(MODE_SET_MOT, 9'd7, 7'd0, 6'd0, FULL_MASK, 1'b1, '0, 1'b0);
    // oversized width saturates
    add_word(MODE_GET_INTEL, 9'd0, 7'd127, 6'd0, '0);
    add_word(MODE_SET_MOT, 9'd7, 7'd100, 6'd0, 64'hFEDC_BA98_7654_3210);
    // misaligned 64-bit field spans nine bytes
    add_word(MODE_SET_INTEL, 9'd5, 7'd64, 6'd0, 64'h8000_0000_0000_0001);
    add_word(MODE_GET_INTEL, 9'd5, 7'd64, 6'd0, '0);
    add_word(MODE_NOP_A, 9'd511, 7'd127, 6'd63, FULL_MASK, 1'b1, '0, 1'b0);
    add_word(MODE_NOP_B, 9'd0, 7'd64, 6'd0, FULL_MASK, 1'b1, '0, 1'b0);
    add_word(MODE_BYTE_RD, 9'd0, 7'd1, 6'd0, '0);
  endtask

  // Push one random word, often followed by a read-back; count non-no-ops
  task automatic add_random_words(output int added);
    int unsigned pick;
    int unsigned eff;
    int unsigned seq;
    logic [2:0]  mode;
    logic [6:0]  size;
    logic [8:0]  pos;
    logic [5:0]  idx;
    logic [63:0] val;
    added = 0;
    pick = $urandom_range(99);
    if (pick < 3) begin
      mode = $urandom_range(1) ? MODE_NOP_B : MODE_NOP_A;
    end else if (pick < 18) begin
      mode = $urandom_range(1) ? MODE_BYTE_WR : MODE_BYTE_RD;
    end else begin
      case ($urandom_range(3))
        0: mode = MODE_GET_MOT;
        1: mode = MODE_SET_MOT;
        2: mode = MODE_GET_INTEL;
        default: mode = MODE_SET_INTEL;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      size = 7'd0;
    end else if (pick < 9) begin
      size = 7'($urandom_range(127, 65));
    end else if (pick < 15) begin
      size = 7'd64;
    end else begin
      size = 7'($urandom_range(64, 1));
    end
    eff = (size > 7'd64) ? 64 : ((size == 7'd0) ? 1 : size);
    if ($urandom_range(99) < 85) begin
      // keep the field inside the buffer
      seq = $urandom_range(512 - eff, 0);
      pos = (mode == MODE_GET_MOT || mode == MODE_SET_MOT) ? 9'(seq ^ 32'd7) : 9'(seq);
    end else begin
      pos = 9'($urandom_range(511));
    end
    idx = 6'($urandom_range(63));
    pick = $urandom_range(9);
    if (pick == 0) begin
      val = FULL_MASK;
    end else if (pick == 1) begin
      val = '0;
    end else begin
      val = {$urandom, $urandom};
    end
    add_word(mode, pos, size, idx, val);
    if (mode != MODE_NOP_A && mode != MODE_NOP_B) added++;
    if ($urandom_range(99) < 50) begin
      if (mode == MODE_SET_MOT) begin
        add_word(MODE_GET_MOT, pos, size, idx, {$urandom, $urandom});
        added++;
      end else if (mode == MODE_SET_INTEL) begin
        add_word(MODE_GET_INTEL, pos, size, idx, {$urandom, $urandom});
        added++;
      end else if (mode == MODE_BYTE_WR) begin
        add_word(MODE_BYTE_RD, pos, size, idx, {$urandom, $urandom});
        added++;
      end
    end
  endtask

  function automatic int unsigned idle_pct(input int unsigned n);
    if (n < word_q.size() / 3) return 13;
    if (n < 2 * word_q.size() / 3) return 61;
    return 0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : drive_word
    bit       took;
    cbf_rsp_t predicted;
    if (rst_ni) begin
      took = start && !busy;
      if (took) begin
        predicted = access_frame(word_q[sent_cnt].req);
        due_rsp_q.push_back(word_q[sent_cnt].typed ? word_q[sent_cnt].rsp : predicted);
        sent_cnt++;
      end
      // hold the word until taken, then maybe idle
      if (!start || took) begin
        if (sent_cnt < word_q.size() && $urandom_range(99) >= idle_pct(sent_cnt)) begin
          start <= 1'b1;
          req_i <= word_q[sent_cnt].req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_word
    cbf_rsp_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done_o) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_o.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, predicted %h",
                                      rsp_o.read_value, want.read_value));
          if (rsp_o.error !== want.error)
            report_mismatch($sformatf("error %b, predicted %b", rsp_o.error, want.error));
        end
      end
    end
  end

  initial begin : run
    int  counted;
    int  added;
    bit  timed_out;
    counted = 0;
    timed_out = 1'b0;
    for (int b = 0; b < BUFFER_BYTES; b++) frame_mirror[b] = 8'h00;
    build_directed();
    while (counted < RANDOM_WORDS) begin
      add_random_words(added);
      counted += added;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!timed_out && (sent_cnt < word_q.size() || due_rsp_q.size() != 0)) begin
      @(posedge clk_i);
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("TB_ERROR");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatches == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cbf_pkg.sv
rtl/cbf_ram.sv
rtl/cbf_merge.sv
rtl/can_signal_bitfield_access.sv
dv/tb_can_signal_bitfield_access.sv
